// File: design/tachometer_period_average_rpm_defines.svh
// Assertion helpers for the tachometer block.
// Each helper expands to one labelled concurrent assertion, or to nothing
// when the code is read by synthesis.
`ifndef TACHOMETER_PERIOD_AVERAGE_RPM_DEFINES_SVH
`define TACHOMETER_PERIOD_AVERAGE_RPM_DEFINES_SVH
`ifndef SYNTHESIS
`define TPAR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tpar: same-cycle check failed");
`define TPAR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tpar: next-cycle check failed");
`else
`define TPAR_ASSERT_IMP(label, clk, rst, ante, cons)
`define TPAR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: design/tpar_pkg.sv
`default_nettype none

package tpar_pkg;

   // Width of the shared datapath: covers a 64-deep ring sum times a 16-bit tick time
   localparam int WORK_W = 54;
   // Narrow operand of the multiplier
   localparam int MUL_W  = 16;
   // Numerator shift register and quotient width
   localparam int NUM_W  = 33;
   // Division steps: 24 bits of the fixed numerator, 33 bits of the scaled rate
   localparam int DIV1_STEPS = 24;
   localparam int DIV2_STEPS = 33;

   localparam logic [23:0] RATE_NUMERATOR = 24'd10000000;

   // Configuration register indexes
   localparam logic [2:0] CSR_TICK_TIME_FIRST  = 3'd0;
   localparam logic [2:0] CSR_TICK_TIME_SECOND = 3'd1;
   localparam logic [2:0] CSR_COMPENSATION     = 3'd2;
   localparam logic [2:0] CSR_MINUTE_FACTOR    = 3'd3;
   localparam logic [2:0] CSR_DIVIDE_VALUE     = 3'd4;
   localparam logic [2:0] CSR_MULTIPLY_VALUE   = 3'd5;
   localparam logic [2:0] CSR_AVERAGE_SHIFT    = 3'd6;
   localparam logic [2:0] CSR_STALL_LIMIT      = 3'd7;

   // Configuration reset values
   localparam logic [15:0] RST_TICK_TIME      = 16'd10;
   localparam logic [15:0] RST_COMPENSATION   = 16'd0;
   localparam logic [7:0]  RST_MINUTE_FACTOR  = 8'd60;
   localparam logic [15:0] RST_DIVIDE_VALUE   = 16'd1;
   localparam logic [7:0]  RST_MULTIPLY_VALUE = 8'd1;
   localparam logic [2:0]  RST_AVERAGE_SHIFT  = 3'd3;
   localparam logic [31:0] RST_STALL_LIMIT    = 32'd2000000;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_PULSE = 2'd1,
      OP_READ  = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_VALID   = 2'd0,
      STATUS_STALLED = 2'd1,
      STATUS_NODATA  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ALU_ADD = 2'd0,
      ALU_MUL = 2'd1,
      ALU_DIV = 2'd2
   } alu_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SUM,
      S_MUL_TT,
      S_CHECK,
      S_DIV1,
      S_ADD_COMP,
      S_MUL_MIN,
      S_DIV2,
      S_MUL_OUT,
      S_RESP
   } state_type;

endpackage

`default_nettype wire

// File: design/tachometer_period_average_rpm.sv
// Channel | Direction | Handshake            | Payload
// req     | in        | req_tvalid/tready    | tdata: opcode; tuser: channel
// rsp     | out       | rsp_tvalid/tready    | tdata: rate; tuser: status, channel
// csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// Tick and pulse words complete without leaving the idle state; opcode 3 is dropped.
// A read loads the result register after the ring sweep (through the registered store
// read) and two restoring divisions of 24 and 33 steps on the single shared unit;
// req_tready returns as the result is loaded, so a read holds the input until then.
// A stalled read goes straight to the result state; an empty ring skips both divisions.
// Reset is synchronous and active high and clears the ring at once through valid bits.
// req_tready is low during a read; a result not taken holds the sequencer in its last state.
`default_nettype none
`include "tachometer_period_average_rpm_defines.svh"

module tachometer_period_average_rpm #(
   parameter int HISTORY_DEPTH = 8,
   parameter int CHANNELS      = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [1:0] opcode, [7:2] zero
   input  wire logic        req_tuser,   // [0] channel
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,   // [31:0] rate
   output logic      [2:0]  rsp_tuser,   // [1:0] status, [2] which_channel
   // configuration write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   localparam int WORK_W    = tpar_pkg::WORK_W;
   localparam int NUM_W     = tpar_pkg::NUM_W;
   localparam int MEM_DEPTH = CHANNELS * HISTORY_DEPTH;
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int SLOT_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W     = ($clog2(HISTORY_DEPTH + 1) > 6) ? $clog2(HISTORY_DEPTH + 1) : 6;

   // configuration
   logic [15:0] cfg_tick_first_ff;
   logic [15:0] cfg_tick_second_ff;
   logic [15:0] cfg_comp_ff;
   logic [7:0]  cfg_minute_ff;
   logic [15:0] cfg_divide_ff;
   logic [7:0]  cfg_multiply_ff;
   logic [2:0]  cfg_shift_ff;
   logic [31:0] cfg_stall_ff;

   // per-channel state
   logic [31:0]       tick_ff [CHANNELS];
   logic [31:0]       tick_in [CHANNELS];
   logic [SLOT_W-1:0] slot_ff [CHANNELS];
   logic [SLOT_W-1:0] slot_in [CHANNELS];

   // sequencer
   tpar_pkg::state_type  state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [WORK_W-1:0]    acc_ff, acc_in;
   logic [WORK_W-1:0]    rem_ff, rem_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic                 ch_ff, ch_in;
   tpar_pkg::status_type status_ff, status_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_rate_ff, rsp_rate_in;
   tpar_pkg::status_type rsp_status_ff, rsp_status_in;
   logic                 rsp_chan_ff, rsp_chan_in;

   // request decode
   tpar_pkg::opcode_type req_op;
   logic                 req_fire;
   logic                 ch_ok;
   logic [31:0]          tick_sel;
   logic [SLOT_W-1:0]    slot_sel;
   logic                 stalled;

   // datapath
   tpar_pkg::alu_op_type alu_op;
   logic [WORK_W-1:0]    alu_a, alu_b, alu_res;
   logic                 alu_bit, alu_q;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_addr, wr_addr;
   logic [31:0]          rd_data;
   logic                 wr_en;
   logic [15:0]          tt_sel;
   logic [WORK_W-1:0]    div_wide;
   logic                 rsp_free;
   logic [31:0]          rate_sat;

   assign req_tready = (state_ff == tpar_pkg::S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_op     = tpar_pkg::opcode_type'(req_tdata[1:0]);
   assign ch_ok      = ({1'b0, req_tuser} < 2'(CHANNELS));
   assign csr_ready  = 1'b1;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // pick the addressed channel's count and ring slot
   always_comb begin
      tick_sel = '0;
      slot_sel = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         if (int'(req_tuser) == c) begin
            tick_sel = tick_ff[c];
            slot_sel = slot_ff[c];
         end
      end
   end

   assign stalled  = (tick_sel >= cfg_stall_ff);
   assign tt_sel   = ch_ff ? cfg_tick_second_ff : cfg_tick_first_ff;
   // a divisor of zero counts as one
   assign div_wide = (cfg_divide_ff == 16'd0) ? WORK_W'(1) : WORK_W'(cfg_divide_ff);
   assign rate_sat = (acc_ff[WORK_W-1:32] != '0) ? '1 : acc_ff[31:0];

   // store a pulse's period in the addressed channel's ring
   assign wr_en   = req_fire && ch_ok && (req_op == tpar_pkg::OP_PULSE);
   assign wr_addr = (req_tuser ? ADDR_W'(HISTORY_DEPTH) : ADDR_W'(0)) + ADDR_W'(slot_sel);

   tpar_hist #(
      .DEPTH   (MEM_DEPTH)
   ) u_hist (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (tick_sel),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tpar_alu u_alu (
      .op     (alu_op),
      .a      (alu_a),
      .b      (alu_b),
      .bit_in (alu_bit),
      .res    (alu_res),
      .q      (alu_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tpar_pkg::S_IDLE: begin
            if (req_fire && ch_ok && (req_op == tpar_pkg::OP_READ)) begin
               state_in = stalled ? tpar_pkg::S_RESP : tpar_pkg::S_SUM;
            end
         end
         tpar_pkg::S_SUM: begin
            if (cnt_ff == CNT_W'(HISTORY_DEPTH)) begin
               state_in = tpar_pkg::S_MUL_TT;
            end
         end
         tpar_pkg::S_MUL_TT: begin
            state_in = tpar_pkg::S_CHECK;
         end
         tpar_pkg::S_CHECK: begin
            state_in = (acc_ff == '0) ? tpar_pkg::S_RESP : tpar_pkg::S_DIV1;
         end
         tpar_pkg::S_DIV1: begin
            if (cnt_ff == CNT_W'(tpar_pkg::DIV1_STEPS - 1)) begin
               state_in = tpar_pkg::S_ADD_COMP;
            end
         end
         tpar_pkg::S_ADD_COMP: begin
            state_in = tpar_pkg::S_MUL_MIN;
         end
         tpar_pkg::S_MUL_MIN: begin
            state_in = tpar_pkg::S_DIV2;
         end
         tpar_pkg::S_DIV2: begin
            if (cnt_ff == CNT_W'(tpar_pkg::DIV2_STEPS - 1)) begin
               state_in = tpar_pkg::S_MUL_OUT;
            end
         end
         tpar_pkg::S_MUL_OUT: begin
            state_in = tpar_pkg::S_RESP;
         end
         tpar_pkg::S_RESP: begin
            if (rsp_free) begin
               state_in = tpar_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = tpar_pkg::S_IDLE;
         end
      endcase
   end

   // steer the shared unit and the ring read port
   always_comb begin
      alu_op  = tpar_pkg::ALU_ADD;
      alu_a   = acc_ff;
      alu_b   = '0;
      alu_bit = 1'b0;
      rd_en   = 1'b0;
      rd_addr = (ch_ff ? ADDR_W'(HISTORY_DEPTH) : ADDR_W'(0)) + ADDR_W'(cnt_ff[SLOT_W-1:0]);
      case (state_ff)
         tpar_pkg::S_SUM: begin
            // issue one read a cycle; add the word returned from the read before
            rd_en = (cnt_ff < CNT_W'(HISTORY_DEPTH));
            alu_b = (cnt_ff == '0) ? '0 : WORK_W'(rd_data);
         end
         tpar_pkg::S_MUL_TT: begin
            alu_op = tpar_pkg::ALU_MUL;
            alu_a  = acc_ff >> cfg_shift_ff;
            alu_b  = WORK_W'(tt_sel);
         end
         tpar_pkg::S_DIV1: begin
            alu_op  = tpar_pkg::ALU_DIV;
            alu_a   = rem_ff;
            alu_b   = acc_ff;
            alu_bit = num_ff[NUM_W-1];
         end
         tpar_pkg::S_ADD_COMP: begin
            alu_a = WORK_W'(quo_ff);
            alu_b = WORK_W'(cfg_comp_ff);
         end
         tpar_pkg::S_MUL_MIN: begin
            alu_op = tpar_pkg::ALU_MUL;
            alu_b  = WORK_W'(cfg_minute_ff);
         end
         tpar_pkg::S_DIV2: begin
            alu_op  = tpar_pkg::ALU_DIV;
            alu_a   = rem_ff;
            alu_b   = div_wide;
            alu_bit = num_ff[NUM_W-1];
         end
         tpar_pkg::S_MUL_OUT: begin
            alu_op = tpar_pkg::ALU_MUL;
            alu_a  = WORK_W'(quo_ff);
            alu_b  = WORK_W'(cfg_multiply_ff);
         end
         default: begin
            alu_op = tpar_pkg::ALU_ADD;
         end
      endcase
   end

   // per-channel counts and ring slots
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         tick_in[c] = tick_ff[c];
         slot_in[c] = slot_ff[c];
         if (req_fire && ch_ok && (int'(req_tuser) == c)) begin
            if (req_op == tpar_pkg::OP_TICK) begin
               // saturate rather than wrap
               if (tick_ff[c] != '1) begin
                  tick_in[c] = tick_ff[c] + 32'd1;
               end
            end else if (req_op == tpar_pkg::OP_PULSE) begin
               tick_in[c] = '0;
               slot_in[c] = (slot_ff[c] == SLOT_W'(HISTORY_DEPTH - 1)) ?
                            '0 : slot_ff[c] + SLOT_W'(1);
            end
         end
      end
   end

   // sequencer working registers and result register
   always_comb begin
      cnt_in        = cnt_ff;
      acc_in        = acc_ff;
      rem_in        = rem_ff;
      num_in        = num_ff;
      quo_in        = quo_ff;
      ch_in         = ch_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_rate_in   = rsp_rate_ff;
      rsp_status_in = rsp_status_ff;
      rsp_chan_in   = rsp_chan_ff;
      case (state_ff)
         tpar_pkg::S_IDLE: begin
            if (req_fire && ch_ok && (req_op == tpar_pkg::OP_READ)) begin
               ch_in     = req_tuser;
               acc_in    = '0;
               cnt_in    = '0;
               status_in = stalled ? tpar_pkg::STATUS_STALLED : tpar_pkg::STATUS_VALID;
            end
         end
         tpar_pkg::S_SUM: begin
            acc_in = alu_res;
            cnt_in = cnt_ff + CNT_W'(1);
         end
         tpar_pkg::S_MUL_TT: begin
            acc_in = alu_res;
         end
         tpar_pkg::S_CHECK: begin
            // a zero product means nothing to divide by
            status_in = (acc_ff == '0) ? tpar_pkg::STATUS_NODATA : tpar_pkg::STATUS_VALID;
            rem_in    = '0;
            quo_in    = '0;
            cnt_in    = '0;
            num_in    = NUM_W'(tpar_pkg::RATE_NUMERATOR) << (NUM_W - tpar_pkg::DIV1_STEPS);
         end
         tpar_pkg::S_DIV1, tpar_pkg::S_DIV2: begin
            rem_in = alu_res;
            quo_in = {quo_ff[NUM_W-2:0], alu_q};
            num_in = num_ff << 1;
            cnt_in = cnt_ff + CNT_W'(1);
         end
         tpar_pkg::S_ADD_COMP: begin
            acc_in = alu_res;
         end
         tpar_pkg::S_MUL_MIN: begin
            acc_in = alu_res;
            num_in = alu_res[NUM_W-1:0];
            rem_in = '0;
            quo_in = '0;
            cnt_in = '0;
         end
         tpar_pkg::S_MUL_OUT: begin
            acc_in = alu_res;
         end
         tpar_pkg::S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_rate_in   = rate_sat;
               rsp_status_in = status_ff;
               rsp_chan_in   = ch_ff;
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   // control registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= tpar_pkg::S_IDLE;
         cnt_ff             <= '0;
         rsp_valid_ff       <= 1'b0;
         cfg_tick_first_ff  <= tpar_pkg::RST_TICK_TIME;
         cfg_tick_second_ff <= tpar_pkg::RST_TICK_TIME;
         cfg_comp_ff        <= tpar_pkg::RST_COMPENSATION;
         cfg_minute_ff      <= tpar_pkg::RST_MINUTE_FACTOR;
         cfg_divide_ff      <= tpar_pkg::RST_DIVIDE_VALUE;
         cfg_multiply_ff    <= tpar_pkg::RST_MULTIPLY_VALUE;
         cfg_shift_ff       <= tpar_pkg::RST_AVERAGE_SHIFT;
         cfg_stall_ff       <= tpar_pkg::RST_STALL_LIMIT;
         for (int c = 0; c < CHANNELS; c++) begin
            tick_ff[c] <= '0;
            slot_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int c = 0; c < CHANNELS; c++) begin
            tick_ff[c] <= tick_in[c];
            slot_ff[c] <= slot_in[c];
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               tpar_pkg::CSR_TICK_TIME_FIRST:  cfg_tick_first_ff  <= csr_data[15:0];
               tpar_pkg::CSR_TICK_TIME_SECOND: cfg_tick_second_ff <= csr_data[15:0];
               tpar_pkg::CSR_COMPENSATION:     cfg_comp_ff        <= csr_data[15:0];
               tpar_pkg::CSR_MINUTE_FACTOR:    cfg_minute_ff      <= csr_data[7:0];
               tpar_pkg::CSR_DIVIDE_VALUE:     cfg_divide_ff      <= csr_data[15:0];
               tpar_pkg::CSR_MULTIPLY_VALUE:   cfg_multiply_ff    <= csr_data[7:0];
               tpar_pkg::CSR_AVERAGE_SHIFT:    cfg_shift_ff       <= csr_data[2:0];
               tpar_pkg::CSR_STALL_LIMIT:      cfg_stall_ff       <= csr_data;
               default: begin
                  cfg_stall_ff <= cfg_stall_ff;
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      acc_ff        <= acc_in;
      rem_ff        <= rem_in;
      num_ff        <= num_in;
      quo_ff        <= quo_in;
      ch_ff         <= ch_in;
      status_ff     <= status_in;
      rsp_rate_ff   <= rsp_rate_in;
      rsp_status_ff <= rsp_status_in;
      rsp_chan_ff   <= rsp_chan_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_rate_ff;
   assign rsp_tuser  = {rsp_chan_ff, rsp_status_ff};

   // counts only move while the sequencer is idle
   `TPAR_ASSERT_NEXT(a_tick_hold, clock, reset, (state_ff != tpar_pkg::S_IDLE), $stable(tick_ff[0]))
   // restoring division keeps the partial remainder below the divisor
   `TPAR_ASSERT_IMP(a_div1_rem, clock, reset, (state_ff == tpar_pkg::S_DIV1), (rem_ff < acc_ff))
   `TPAR_ASSERT_IMP(a_div2_rem, clock, reset, (state_ff == tpar_pkg::S_DIV2), (rem_ff < div_wide))
   // the reciprocal never exceeds its numerator
   `TPAR_ASSERT_IMP(a_recip_range, clock, reset, (state_ff == tpar_pkg::S_ADD_COMP), (quo_ff <= NUM_W'(tpar_pkg::RATE_NUMERATOR)))
   // a fresh result is loaded only from the final state
   `TPAR_ASSERT_IMP(a_rsp_source, clock, reset, (!rsp_valid_ff && rsp_valid_in), (state_ff == tpar_pkg::S_RESP))
   // stalled and empty results carry a zero rate
   `TPAR_ASSERT_IMP(a_zero_rate, clock, reset, (rsp_valid_ff && (rsp_status_ff != tpar_pkg::STATUS_VALID)), (rsp_rate_ff == 32'd0))

endmodule

`default_nettype wire

// File: design/tpar_hist.sv
`default_nettype none

// Period ring store for all channels, one word per entry, registered read.
// A valid bit per entry makes unwritten entries read as zero.
module tpar_hist #(
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [31:0]       wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [31:0]       rd_data
);

   logic [31:0]      hist_mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [31:0]      rd_word_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_word_ff <= hist_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : 32'd0;

endmodule

`default_nettype wire

// File: design/tpar_alu.sv
`default_nettype none

// Shared arithmetic unit: accumulate, narrow multiply, one restoring division step.
module tpar_alu (
   input  wire tpar_pkg::alu_op_type                op,
   input  wire logic [tpar_pkg::WORK_W-1:0]         a,
   input  wire logic [tpar_pkg::WORK_W-1:0]         b,
   input  wire logic                                bit_in,
   output logic      [tpar_pkg::WORK_W-1:0]         res,
   output logic                                     q
);

   logic [tpar_pkg::WORK_W+tpar_pkg::MUL_W-1:0] prod;
   logic [tpar_pkg::WORK_W:0]                   trial;
   logic [tpar_pkg::WORK_W:0]                   diff;

   always_comb begin
      prod  = {{tpar_pkg::MUL_W{1'b0}}, a} *
              {{tpar_pkg::WORK_W{1'b0}}, b[tpar_pkg::MUL_W-1:0]};
      trial = {a, bit_in};
      diff  = trial - {1'b0, b};
      res   = '0;
      q     = 1'b0;
      case (op)
         tpar_pkg::ALU_ADD: begin
            res = a + b;
         end
         tpar_pkg::ALU_MUL: begin
            res = prod[tpar_pkg::WORK_W-1:0];
         end
         tpar_pkg::ALU_DIV: begin
            // shift in the next numerator bit, subtract the divisor if it fits
            if (trial >= {1'b0, b}) begin
               res = diff[tpar_pkg::WORK_W-1:0];
               q   = 1'b1;
            end else begin
               res = trial[tpar_pkg::WORK_W-1:0];
            end
         end
         default: begin
            res = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: dv/tb.sv
module tb;

   // Ring depth and channel count of the block under test
   localparam int HISTORY_DEPTH = 8;
   localparam int CHANNELS      = 2;

   // Opcode left unused by the block; its words are dropped
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Numerator of the reciprocal division
   localparam logic [63:0] RATE_DIVIDEND = 64'd10000000;

   // A read holds the input until its result is loaded; wait out the settle time
   // before any register write
   localparam int SETTLE_CYCLES = 120;
   // Long receiver hold-off, so that a read result blocks the block and its input
   localparam int HOLD_OFF_CYCLES = 400;
   // Cycle budget for the whole run
   localparam int CYCLE_LIMIT = 1000000;
   // Random words per phase, and the number of random phases
   localparam int PHASE_WORDS = 204;
   localparam int RANDOM_PHASES = 8;

   typedef struct {
      logic [31:0]          rate;
      tpar_pkg::status_type status;
      logic                 which_channel;
   } rate_result_type;

   typedef struct {
      logic [15:0] tick_time_first;
      logic [15:0] tick_time_second;
      logic [15:0] compensation;
      logic [7:0]  minute_factor;
      logic [15:0] divide_value;
      logic [7:0]  multiply_value;
      logic [2:0]  average_shift;
      logic [31:0] stall_limit;
   } rate_setting_type;

   // Holds its own copy of the registers and of the channel state, and
   // queues the rate that each accepted read word must produce.
   class rate_scoreboard_type;
      logic [15:0]     tick_time [CHANNELS];
      logic [15:0]     compensation;
      logic [7:0]      minute_factor;
      logic [15:0]     divide_value;
      logic [7:0]      multiply_value;
      logic [2:0]      average_shift;
      logic [31:0]     stall_limit;
      logic [31:0]     tick_count [CHANNELS];
      logic [31:0]     period_ring [CHANNELS][HISTORY_DEPTH];
      int unsigned     ring_slot [CHANNELS];
      rate_result_type expected_rates [$];
      int unsigned     mismatches;

      function new();
         tick_time[0]   = tpar_pkg::RST_TICK_TIME;
         tick_time[1]   = tpar_pkg::RST_TICK_TIME;
         compensation   = tpar_pkg::RST_COMPENSATION;
         minute_factor  = tpar_pkg::RST_MINUTE_FACTOR;
         divide_value   = tpar_pkg::RST_DIVIDE_VALUE;
         multiply_value = tpar_pkg::RST_MULTIPLY_VALUE;
         average_shift  = tpar_pkg::RST_AVERAGE_SHIFT;
         stall_limit    = tpar_pkg::RST_STALL_LIMIT;
         for (int c = 0; c < CHANNELS; c++) begin
            tick_count[c] = '0;
            ring_slot[c]  = 0;
            for (int k = 0; k < HISTORY_DEPTH; k++)
               period_ring[c][k] = '0;
         end
         mismatches = 0;
      endfunction

      function void write_reg(logic [2:0] index, logic [31:0] data);
         case (index)
            tpar_pkg::CSR_TICK_TIME_FIRST:  tick_time[0]   = data[15:0];
            tpar_pkg::CSR_TICK_TIME_SECOND: tick_time[1]   = data[15:0];
            tpar_pkg::CSR_COMPENSATION:     compensation   = data[15:0];
            tpar_pkg::CSR_MINUTE_FACTOR:    minute_factor  = data[7:0];
            tpar_pkg::CSR_DIVIDE_VALUE:     divide_value   = data[15:0];
            tpar_pkg::CSR_MULTIPLY_VALUE:   multiply_value = data[7:0];
            tpar_pkg::CSR_AVERAGE_SHIFT:    average_shift  = data[2:0];
            tpar_pkg::CSR_STALL_LIMIT:      stall_limit    = data;
            default: ;
         endcase
      endfunction

      function rate_result_type predict_rate(logic ch);
         rate_result_type res;
         logic [63:0]     ring_sum;
         logic [63:0]     product;
         logic [63:0]     value;
         logic [63:0]     divisor;
         res.rate          = '0;
         res.which_channel = ch;
         if (tick_count[ch] >= stall_limit) begin
            res.status = tpar_pkg::STATUS_STALLED;
            return res;
         end
         ring_sum = '0;
         for (int k = 0; k < HISTORY_DEPTH; k++)
            ring_sum += {32'd0, period_ring[ch][k]};
         ring_sum = ring_sum >> average_shift;
         product  = ring_sum * {48'd0, tick_time[ch]};
         if (product == 0) begin
            res.status = tpar_pkg::STATUS_NODATA;
            return res;
         end
         divisor = (divide_value == 0) ? 64'd1 : {48'd0, divide_value};
         value = RATE_DIVIDEND / product;
         value = value + {48'd0, compensation};
         value = value * {56'd0, minute_factor};
         value = value / divisor;
         value = value * {56'd0, multiply_value};
         res.rate   = (value > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : value[31:0];
         res.status = tpar_pkg::STATUS_VALID;
         return res;
      endfunction

      function void note_request(logic [1:0] op, logic ch);
         if (op == tpar_pkg::OP_TICK) begin
            if (tick_count[ch] != 32'hFFFF_FFFF)
               tick_count[ch] = tick_count[ch] + 32'd1;
         end else if (op == tpar_pkg::OP_PULSE) begin
            period_ring[ch][ring_slot[ch]] = tick_count[ch];
            ring_slot[ch]  = (ring_slot[ch] + 1) % HISTORY_DEPTH;
            tick_count[ch] = '0;
         end else if (op == tpar_pkg::OP_READ)
            expected_rates.push_back(predict_rate(ch));
      endfunction

      function void check_result(logic [31:0] rate, logic [1:0] status, logic ch);
         rate_result_type want;
         if (expected_rates.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected rate word: rate %0d status %0d channel %0d",
                        rate, status, ch);
            mismatches++;
            return;
         end
         want = expected_rates.pop_front();
         if (rate !== want.rate || status !== want.status || ch !== want.which_channel) begin
            if (mismatches < 10)
               $display({"rate mismatch: expected rate %0d status %0d channel %0d,",
                         " got rate %0d status %0d channel %0d"},
                        want.rate, want.status, want.which_channel, rate, status, ch);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_rates.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   // Random idling on both sides; cleared for the directed part, the fifth phase and the last phase
   bit idle_enable;
   // Set by the stimulus to ask the receiver for one long hold-off
   bit hold_off_pending;
   int unsigned cycle_count;

   rate_scoreboard_type rate_board;

   tachometer_period_average_rpm #(
      .HISTORY_DEPTH(HISTORY_DEPTH),
      .CHANNELS     (CHANNELS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Clock: period of 10 time units
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Sample both handshakes at the rising edge: note each accepted request word
   // in the predictor, and check each accepted result word against the oldest
   // expectation.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            rate_board.note_request(req_tdata[1:0], req_tuser);
         if (rsp_tvalid && rsp_tready)
            rate_board.check_result(rsp_tdata, rsp_tuser[1:0], rsp_tuser[2]);
      end
   end

   // Receiver: take results at full rate, drop ready in random bursts
   // while idling is on, and hold off for a long stretch once when asked.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
         end else if (idle_enable && $urandom_range(0, 11) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 14)) @(negedge clock);
         end else
            rsp_tready <= 1'b1;
      end
   end

   // Watchdog: count cycles and give up at the limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   // Offer one request word and hold it until accepted. Enter and leave at a
   // falling edge; an optional random gap comes first while idling is on.
   task automatic send_word(logic [1:0] op, logic ch);
      if (idle_enable && $urandom_range(0, 9) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, op};
      req_tuser  <= ch;
      do
         @(posedge clock);
      while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_ticks(int unsigned n, logic ch);
      repeat (n) send_word(tpar_pkg::OP_TICK, ch);
   endtask

   // Write one register and mirror it in the predictor once accepted
   task automatic write_csr(logic [2:0] index, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do
         @(posedge clock);
      while (!csr_ready);
      rate_board.write_reg(index, data);
      @(negedge clock);
   endtask

   task automatic configure(rate_setting_type s);
      write_csr(tpar_pkg::CSR_TICK_TIME_FIRST,  {16'd0, s.tick_time_first});
      write_csr(tpar_pkg::CSR_TICK_TIME_SECOND, {16'd0, s.tick_time_second});
      write_csr(tpar_pkg::CSR_COMPENSATION,     {16'd0, s.compensation});
      write_csr(tpar_pkg::CSR_MINUTE_FACTOR,    {24'd0, s.minute_factor});
      write_csr(tpar_pkg::CSR_DIVIDE_VALUE,     {16'd0, s.divide_value});
      write_csr(tpar_pkg::CSR_MULTIPLY_VALUE,   {24'd0, s.multiply_value});
      write_csr(tpar_pkg::CSR_AVERAGE_SHIFT,    {29'd0, s.average_shift});
      write_csr(tpar_pkg::CSR_STALL_LIMIT,      s.stall_limit);
      csr_valid <= 1'b0;
   endtask

   // Drop valid, wait for every pending result, then let the block run out
   // before anything else happens. Leave at a falling edge.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (rate_board.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic rate_setting_type random_setting();
      rate_setting_type s;
      s.tick_time_first  = $urandom_range(0, 1) ? 16'($urandom_range(1, 20))
                                                : 16'($urandom_range(1, 65535));
      s.tick_time_second = $urandom_range(0, 1) ? 16'($urandom_range(1, 20))
                                                : 16'($urandom_range(1, 65535));
      s.compensation     = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(0, 65535));
      s.minute_factor    = 8'($urandom_range(1, 255));
      s.divide_value     = $urandom_range(0, 1) ? 16'($urandom_range(1, 16))
                                                : 16'($urandom_range(1, 65535));
      s.multiply_value   = 8'($urandom_range(1, 255));
      s.average_shift    = 3'($urandom_range(0, 6));
      if ($urandom_range(0, 2) != 0)
         s.stall_limit = $urandom_range(4, 40);
      else begin
         s.stall_limit = $urandom;
         if (s.stall_limit == 0)
            s.stall_limit = 32'd1;
      end
      return s;
   endfunction

   // Mostly well-formed measurement runs: ticks, a pulse, sometimes a read.
   // Mix in stray reads in the middle of a run, pulses with no ticks and
   // noise words, unused opcode among them.
   task automatic run_phase(int unsigned n_words);
      int unsigned sent;
      int unsigned run_len;
      logic        ch;
      logic [1:0]  op;
      sent = 0;
      while (sent < n_words) begin
         ch = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 99) < 10) begin
            op = 2'($urandom_range(0, 3));
            send_word(op, ch);
            if (op != OP_UNUSED)
               sent++;
         end else begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 12);
            send_ticks(run_len, ch);
            sent += run_len;
            if ($urandom_range(0, 5) == 0) begin
               send_word(tpar_pkg::OP_READ, ch);
               sent++;
            end
            if ($urandom_range(0, 9) != 0) begin
               send_word(tpar_pkg::OP_PULSE, ch);
               sent++;
            end
            if ($urandom_range(0, 1) == 0) begin
               send_word(tpar_pkg::OP_READ, ch);
               sent++;
            end
            if ($urandom_range(0, 7) == 0) begin
               send_word(tpar_pkg::OP_READ, !ch);
               sent++;
            end
         end
      end
   endtask

   initial begin
      rate_setting_type s;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      req_tuser        = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      idle_enable      = 1'b0;
      hold_off_pending = 1'b0;
      reset            = 1'b1;
      rate_board       = new();

      // Hold reset, then release it at a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed, reset values: empty rings give no data, unused opcode is
      // dropped, a single stored period of eight ticks gives a valid rate.
      send_word(tpar_pkg::OP_READ, 1'b0);
      send_word(tpar_pkg::OP_READ, 1'b1);
      send_word(OP_UNUSED, 1'b0);
      send_word(OP_UNUSED, 1'b1);
      send_ticks(8, 1'b1);
      send_word(tpar_pkg::OP_PULSE, 1'b1);
      send_word(tpar_pkg::OP_READ, 1'b1);
      settle();

      // Directed, extreme gains: stalled channel, saturated rate, zero divisor
      // taken as one, zero tick time giving no data.
      s.tick_time_first  = 16'd10;
      s.tick_time_second = 16'd0;
      s.compensation     = 16'hFFFF;
      s.minute_factor    = 8'hFF;
      s.divide_value     = 16'd0;
      s.multiply_value   = 8'hFF;
      s.average_shift    = 3'd0;
      s.stall_limit      = 32'd2;
      configure(s);
      send_ticks(2, 1'b0);
      send_word(tpar_pkg::OP_READ, 1'b0);
      send_word(tpar_pkg::OP_PULSE, 1'b0);
      send_word(tpar_pkg::OP_READ, 1'b0);
      send_word(tpar_pkg::OP_READ, 1'b1);
      settle();

      // Random phases: lowest settings first, then highest, then random ones.
      // Ask for the long hold-off in the third phase; drop idling in the fifth and the last.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0) begin
            s.tick_time_first  = 16'd1;
            s.tick_time_second = 16'd1;
            s.compensation     = 16'd0;
            s.minute_factor    = 8'd1;
            s.divide_value     = 16'd1;
            s.multiply_value   = 8'd1;
            s.average_shift    = 3'd0;
            s.stall_limit      = 32'd1;
         end else if (p == 1) begin
            s.tick_time_first  = 16'hFFFF;
            s.tick_time_second = 16'hFFFF;
            s.compensation     = 16'hFFFF;
            s.minute_factor    = 8'hFF;
            s.divide_value     = 16'hFFFF;
            s.multiply_value   = 8'hFF;
            s.average_shift    = 3'd6;
            s.stall_limit      = 32'hFFFF_FFFF;
         end else
            s = random_setting();
         configure(s);
         idle_enable = (p != RANDOM_PHASES - 1) && (p != 4);
         if (p == 2)
            hold_off_pending = 1'b1;
         run_phase(PHASE_WORDS);
         settle();
      end

      if (rate_board.mismatches == 0 && rate_board.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
